FILE: hdl/pes_pkg.sv
// Package for the product-except-self block: state encoding, field widths and defaults.
// Shared by the top level, its bound checker and the test bench; depends on nothing else.
package pes_pkg;

  localparam int VAL_W           = 32;
  localparam int IDX_W           = 6;
  localparam int DEFAULT_MAX_LEN = 64;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_BACK,
    ST_DRAIN,
    ST_EMIT
  } pes_state_t;

  // Low half of an unsigned 32 x 32 product, which equals the wrapped signed product.
  function automatic logic [VAL_W-1:0] mul_lo(input logic [VAL_W-1:0] a,
                                              input logic [VAL_W-1:0] b);
    logic [2*VAL_W-1:0] full;
    full = {{VAL_W{1'b0}}, a} * {{VAL_W{1'b0}}, b};
    return full[VAL_W-1:0];
  endfunction

endpackage

FILE: hdl/product_except_self_top.sv
// Product-except-self engine: element and prefix memories with load, backward and emit passes.
// Depends on pes_pkg for the state type, field widths and the wrapping multiply.
//
// Words are loaded one per cycle while busy is low; a running prefix product is kept as they
// arrive. The word marked last starts the output phase: a backward pass reads both memories,
// one entry a cycle, multiplying each prefix by the running suffix product and writing the
// result back into the prefix memory, then an emit pass reads it out in index order. For an
// array of n stored words, busy stays high through the backward pass, the drain state and the
// emit pass. The n results appear on consecutive cycles, each marked by strobe for one cycle;
// the final one lands in the first cycle after busy falls, when the next word may already be
// taken. The receiver cannot stall them. The registered reads of the memories add the drain
// state at the end of the backward pass and put a register in front of each result. Words
// beyond MAX_LEN are dropped and the whole set is flagged by overflow.
module product_except_self_top
  import pes_pkg::*;
#(
  parameter int MAX_LEN = DEFAULT_MAX_LEN
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [VAL_W-1:0] value,
  input  logic                    last,
  output logic                    strobe,
  output logic signed [VAL_W-1:0] product,
  output logic        [IDX_W-1:0] index,
  output logic                    last_res,
  output logic                    overflow
);

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CW = $clog2(MAX_LEN + 1);

  pes_state_t state, state_next;

  logic [VAL_W-1:0] elem_mem [MAX_LEN];
  logic [VAL_W-1:0] pre_mem  [MAX_LEN];

  logic [VAL_W-1:0] running_prefix;
  logic [CW-1:0]    count;
  logic             ovf_seen;
  logic [AW-1:0]    last_idx;
  logic [AW-1:0]    ptr;
  logic [VAL_W-1:0] suffix;
  logic             bk_vld;
  logic [AW-1:0]    bk_addr;
  logic [VAL_W-1:0] elem_rd;
  logic [VAL_W-1:0] pre_rd;

  logic             accept;
  logic             store_en;
  logic [CW-1:0]    n_after;
  logic [CW-1:0]    n_m1;
  logic             pre_we;
  logic [AW-1:0]    pre_waddr;
  logic [VAL_W-1:0] pre_wdata;
  logic [VAL_W-1:0] value_u;

  assign value_u  = $unsigned(value);
  assign accept   = start && !busy;
  assign store_en = accept && (count < CW'(MAX_LEN));
  assign n_after  = store_en ? count + CW'(1) : count;
  assign n_m1     = n_after - CW'(1);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD:  if (accept && last) state_next = ST_BACK;
      ST_BACK:  if (ptr == '0) state_next = ST_DRAIN;
      ST_DRAIN: state_next = ST_EMIT;
      ST_EMIT:  if (ptr == last_idx) state_next = ST_LOAD;
      default:  state_next = ST_LOAD;
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    busy = 1'b1;
    case (state)
      ST_LOAD: busy = 1'b0;
      default: busy = 1'b1;
    endcase
  end

  // The prefix memory is written while loading and by the backward pass, never both at once.
  always_comb begin
    pre_we    = store_en || bk_vld;
    pre_waddr = store_en ? count[AW-1:0] : bk_addr;
    pre_wdata = store_en ? running_prefix : mul_lo(pre_rd, suffix);
  end

  always_ff @(posedge clk) begin
    if (store_en) begin
      elem_mem[count[AW-1:0]] <= value_u;
    end
    if (pre_we) begin
      pre_mem[pre_waddr] <= pre_wdata;
    end
    elem_rd <= elem_mem[ptr];
    pre_rd  <= pre_mem[ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_LOAD;
      running_prefix <= VAL_W'(1);
      count          <= '0;
      ovf_seen       <= 1'b0;
      ptr            <= '0;
      bk_vld         <= 1'b0;
      strobe         <= 1'b0;
    end else begin
      state  <= state_next;
      bk_vld <= (state == ST_BACK);
      strobe <= (state == ST_EMIT);
      case (state)
        ST_LOAD: begin
          if (store_en) begin
            running_prefix <= mul_lo(running_prefix, value_u);
            count          <= n_after;
          end else if (accept) begin
            ovf_seen <= 1'b1;
          end
          if (accept && last) begin
            ptr <= n_m1[AW-1:0];
          end
        end
        ST_BACK: begin
          if (ptr != '0) begin
            ptr <= ptr - AW'(1);
          end
        end
        ST_DRAIN: begin
          ptr <= '0;
        end
        ST_EMIT: begin
          ptr <= ptr + AW'(1);
          if (ptr == last_idx) begin
            running_prefix <= VAL_W'(1);
            count          <= '0;
            ovf_seen       <= 1'b0;
          end
        end
        default: begin
          ptr <= '0;
        end
      endcase
    end
  end

  // Payload registers of the backward pass and the result port.
  always_ff @(posedge clk) begin
    bk_addr <= ptr;
    if (state == ST_LOAD && accept && last) begin
      last_idx <= n_m1[AW-1:0];
      suffix   <= VAL_W'(1);
    end else if (bk_vld) begin
      suffix <= mul_lo(suffix, elem_rd);
    end
    index    <= IDX_W'(ptr);
    last_res <= (ptr == last_idx);
    overflow <= ovf_seen;
  end

  assign product = $signed(pre_rd);

endmodule

FILE: hdl/pes_checker.sv
// Port-level checker for the product-except-self block, bound to its top level.
// Depends on pes_pkg for the field widths.
module pes_checker
  import pes_pkg::*;
(
  input logic                    clk,
  input logic                    rst,
  input logic                    start,
  input logic                    busy,
  input logic signed [VAL_W-1:0] value,
  input logic                    last,
  input logic                    strobe,
  input logic signed [VAL_W-1:0] product,
  input logic        [IDX_W-1:0] index,
  input logic                    last_res,
  input logic                    overflow
);

  // A word marked last always opens the output phase.
  a_last_starts: assert property (@(posedge clk) disable iff (rst)
    start && !busy && last |=> busy)
    else $error("last word did not raise busy");

  // Results of a set come back to back and the block stays busy until the final one.
  a_burst: assert property (@(posedge clk) disable iff (rst)
    strobe && !last_res |=> strobe)
    else $error("gap inside a result burst");

  a_busy_in_burst: assert property (@(posedge clk) disable iff (rst)
    strobe && !last_res |-> busy)
    else $error("block idle before the final result");

  a_index_step: assert property (@(posedge clk) disable iff (rst)
    strobe && !last_res |=> index == $past(index) + IDX_W'(1))
    else $error("result index did not advance by one");

  a_ovf_steady: assert property (@(posedge clk) disable iff (rst)
    strobe && !last_res |=> overflow == $past(overflow))
    else $error("overflow flag changed within a set");

endmodule

bind product_except_self_top pes_checker u_pes_checker (.*);

FILE: test/product_except_self_checker.sv
// Checker for the product-except-self block: watches the word and result channels,
// predicts every result set and compares it field by field. Depends on pes_pkg.
module product_except_self_checker
  import pes_pkg::*;
#(
  parameter int MAX_LEN = DEFAULT_MAX_LEN
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic                    busy,
  input  logic signed [VAL_W-1:0] value,
  input  logic                    last,
  input  logic                    strobe,
  input  logic signed [VAL_W-1:0] product,
  input  logic        [IDX_W-1:0] index,
  input  logic                    last_res,
  input  logic                    overflow,
  output int                      errors,
  output int                      pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [VAL_W-1:0] product;
    logic [IDX_W-1:0] index;
    logic             last_res;
    logic             overflow;
  } set_result_t;

  logic [VAL_W-1:0] elem_mem [MAX_LEN];
  logic [VAL_W-1:0] prefix_mem [MAX_LEN];
  logic [VAL_W-1:0] run_prefix;
  logic [6:0]       elem_cnt;
  logic             dropped;
  set_result_t      expected_products [$];

  task automatic flag(input string msg);
    errors++;
    if (errors <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  // Take one word into the array; a word marked last produces the whole set of results.
  task automatic absorb_word(input logic [VAL_W-1:0] v, input logic is_end);
    logic [VAL_W-1:0] suffix;
    logic [VAL_W-1:0] prods [MAX_LEN];
    set_result_t      r;
    int               n;
    int               k;
    if (elem_cnt < MAX_LEN) begin
      elem_mem[elem_cnt]   = v;
      prefix_mem[elem_cnt] = run_prefix;
      run_prefix           = run_prefix * v;
      elem_cnt             = elem_cnt + 7'd1;
    end else begin
      dropped = 1'b1;
    end
    if (is_end) begin
      n      = elem_cnt;
      suffix = 1;
      for (k = n - 1; k >= 0; k--) begin
        prods[k] = prefix_mem[k] * suffix;
        suffix   = suffix * elem_mem[k];
      end
      for (k = 0; k < n; k++) begin
        r.product  = prods[k];
        r.index    = k[IDX_W-1:0];
        r.last_res = (k == n - 1);
        r.overflow = dropped;
        expected_products.push_back(r);
      end
      run_prefix = 1;
      elem_cnt   = '0;
      dropped    = 1'b0;
    end
  endtask

  task automatic compare_result();
    set_result_t r;
    if (expected_products.size() == 0) begin
      flag($sformatf("unexpected result: product %h index %0d last_res %0b overflow %0b",
                     product, index, last_res, overflow));
    end else begin
      r = expected_products.pop_front();
      if (product !== r.product)
        flag($sformatf("index %0d: product expected %h, got %h", r.index, r.product, product));
      if (index !== r.index)
        flag($sformatf("index expected %0d, got %0d", r.index, index));
      if (last_res !== r.last_res)
        flag($sformatf("index %0d: last_res expected %0b, got %0b", r.index, r.last_res,
                       last_res));
      if (overflow !== r.overflow)
        flag($sformatf("index %0d: overflow expected %0b, got %0b", r.index, r.overflow,
                       overflow));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      run_prefix = 1;
      elem_cnt   = '0;
      dropped    = 1'b0;
      expected_products.delete();
    end else begin
      if (strobe) compare_result();
      if (start && !busy) absorb_word(value, last);
    end
    pending <= expected_products.size();
  end

endmodule

FILE: test/product_except_self_top_tb.sv
// Testbench top for product_except_self_top: clock, reset, word stimulus and the verdict.
// Depends on pes_pkg, the block itself and product_except_self_checker.
module product_except_self_top_tb
  import pes_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LEN_MAX     = DEFAULT_MAX_LEN;
  localparam int TOTAL_ITEMS = 350;
  localparam int SETTLE      = 2 * LEN_MAX + 8;

  logic                    clk;
  logic                    rst;
  logic                    start;
  logic                    busy;
  logic signed [VAL_W-1:0] value;
  logic                    last;
  logic                    strobe;
  logic signed [VAL_W-1:0] product;
  logic        [IDX_W-1:0] index;
  logic                    last_res;
  logic                    overflow;
  int                      errors;
  int                      pending;

  int sent;
  bit calm;

  product_except_self_top #(.MAX_LEN(LEN_MAX)) u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .value(value), .last(last),
    .strobe(strobe), .product(product), .index(index), .last_res(last_res),
    .overflow(overflow)
  );

  product_except_self_checker #(.MAX_LEN(LEN_MAX)) u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .value(value), .last(last),
    .strobe(strobe), .product(product), .index(index), .last_res(last_res),
    .overflow(overflow), .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #1ms;
    $display("product_except_self_top_tb: FAIL");
    $finish;
  end

  // Mostly random 32-bit words, with zero, one, minus one and the extremes mixed in.
  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return 32'd1;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h8000_0000;
      4:       return 32'h7FFF_FFFF;
      5, 6, 7: return $urandom_range(0, 6) - 3;
      default: return $urandom;
    endcase
  endfunction

  task automatic maybe_idle();
    if (!calm && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // Present one word and hold it until the block takes it.
  task automatic send_word(input logic [VAL_W-1:0] v, input logic is_end);
    maybe_idle();
    start <= 1'b1;
    value <= v;
    last  <= is_end;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
  endtask

  task automatic send_array(input logic [VAL_W-1:0] vals [$]);
    for (int i = 0; i < vals.size(); i++) send_word(vals[i], i == vals.size() - 1);
  endtask

  task automatic send_set(input int len);
    for (int i = 0; i < len; i++) send_word(pick_value(), i == len - 1);
  endtask

  task automatic wait_drained(input int max_cycles);
    int waited;
    waited = 0;
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 && waited < max_cycles) begin
      @(posedge clk);
      waited++;
    end
  endtask

  initial begin
    logic [VAL_W-1:0] arr [$];
    int len;
    rst   <= 1'b1;
    start <= 1'b0;
    value <= '0;
    last  <= 1'b0;
    sent  = 0;
    calm  = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // A single word gives a product of one.
    arr = '{32'h1234_5678};
    send_array(arr);
    arr = '{32'h8000_0000, 32'h7FFF_FFFF};
    send_array(arr);
    arr = '{32'hFFFF_FFFF, 32'h0, 32'h1, 32'h8000_0000, 32'h7FFF_FFFF};
    send_array(arr);
    arr = '{32'h0, 32'h0, 32'h5};
    send_array(arr);
    arr = '{32'h2, 32'h3, 32'h4, 32'h5};
    send_array(arr);
    arr = '{32'h8000_0000};
    send_array(arr);
    arr = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
    send_array(arr);
    wait_drained(20000);

    // A full store, a last word that is dropped, and a run of dropped words.
    send_set(LEN_MAX);
    wait_drained(20000);
    send_set(LEN_MAX + 1);
    send_set(LEN_MAX + $urandom_range(2, 8));

    while (sent < TOTAL_ITEMS) begin
      if (sent > TOTAL_ITEMS - 60) calm = 1'b1;
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
      send_set(len);
    end

    wait_drained(20000);
    repeat (SETTLE) @(posedge clk);
    if (pending != 0) $display("%0d expected results never arrived", pending);
    if (errors == 0 && pending == 0) begin
      $display("product_except_self_top_tb: PASS");
    end else begin
      $display("product_except_self_top_tb: FAIL");
    end
    $finish;
  end

endmodule
